[rtl/pmse_pkg.sv]
// Shared types, constants and helper functions of the PCM mapper shaping encoder.
package pmse_pkg;

	localparam int TABLE_DEPTH = 128;
	localparam int TABLE_POS   = 6;
	localparam int TBL_WORDS   = TABLE_POS * TABLE_DEPTH;
	localparam int TBL_AW      = $clog2(TBL_WORDS);
	localparam int RING_DEPTH  = 32;
	localparam int RING_AW     = $clog2(RING_DEPTH);
	localparam int FRAME_W     = 62;
	localparam int VAL_W       = FRAME_W - 3;
	localparam int DIV_CW      = $clog2(VAL_W + 1);
	localparam int LEN_W       = 8;
	localparam int UC_W        = 7;
	localparam int SAMP_W      = 16;
	localparam int X_W         = 17;
	localparam int F_W         = 32;
	localparam int PROD_W      = 64;
	localparam int EN_W        = 63;

	// Sign operation masks of the two-state trellis, by {state, predecessor}
	localparam logic [7:0] SIGN_OP1 = 8'h55;
	localparam logic [7:0] SIGN_OP2 = 8'hff;
	localparam logic [7:0] SIGN_OP3 = 8'haa;
	localparam logic [15:0] MU_BIAS = 16'h0084;

	typedef enum logic [2:0] {
		CFG_SHAPING_BITS = 3'd0,
		CFG_DATA_BITS    = 3'd1,
		CFG_LOOKAHEAD    = 3'd2,
		CFG_COEF_A1      = 3'd3,
		CFG_COEF_B1      = 3'd4,
		CFG_COEF_A2      = 3'd5,
		CFG_COEF_B2      = 3'd6
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_DIV_GO, ST_DIV_WAIT, ST_RING, ST_SIGN,
		ST_TRL_GO, ST_TRL_WAIT, ST_OPTR, ST_OUT, ST_DONE
	} enc_state_t;

	typedef enum logic [3:0] {
		T_IDLE, T_EDGE, T_MAG, T_P1, T_P2, T_P3, T_P4, T_P5, T_P6,
		T_NEXT, T_DEPTH, T_DONE
	} trl_fsm_t;

	typedef struct packed {
		logic                   req_type;
		logic [2:0]             table_pos;
		logic [6:0]             table_index;
		logic [UC_W-1:0]        ucode_value;
		logic                   table_final;
		logic [FRAME_W-1:0]     frame_bits;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMP_W-1:0] sample0;
		logic signed [SAMP_W-1:0] sample1;
		logic signed [SAMP_W-1:0] sample2;
		logic signed [SAMP_W-1:0] sample3;
		logic signed [SAMP_W-1:0] sample4;
		logic signed [SAMP_W-1:0] sample5;
	} out_item_t;

	typedef struct packed {
		logic [2:0]        fs;
		logic [1:0]        ld;
		logic signed [7:0] a1;
		logic signed [7:0] b1;
		logic signed [7:0] a2;
		logic signed [7:0] b2;
	} trl_cfg_t;

	// Trellis state handed in at start and back at the end of a shaping frame
	typedef struct packed {
		logic                  q;
		logic [5:0]            t;
		logic signed [X_W-1:0] x;
		logic signed [F_W-1:0] y;
		logic signed [F_W-1:0] v;
	} trl_st_t;

	typedef struct packed {
		logic [5:0]            t;
		logic signed [X_W-1:0] x;
		logic signed [F_W-1:0] y;
		logic signed [F_W-1:0] v;
		logic [EN_W-1:0]       w;
	} node_t;

	// Mu-law magnitude of a Ucode
	function automatic logic [15:0] ucode_mag(input logic [UC_W-1:0] u);
		logic [15:0] t;
		t = ({9'd0, u[3:0], 3'b000} + MU_BIAS) << u[6:4];
		return t - MU_BIAS;
	endfunction

	function automatic logic [5:0] sign_op(input logic [1:0] sel);
		logic [7:0] r;
		case (sel)
			2'd0: r = 8'h00;
			2'd1: r = SIGN_OP1;
			2'd2: r = SIGN_OP2;
			default: r = SIGN_OP3;
		endcase
		return r[5:0];
	endfunction

endpackage

[rtl/pmse_ram.sv]
// Generic single-write, registered-read RAM.
module pmse_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/pmse_div.sv]
// Bit-serial restoring divider giving quotient and remainder by a table length.
module pmse_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [pmse_pkg::VAL_W-1:0] dividend,
	input  logic [pmse_pkg::LEN_W-1:0] divisor,
	output logic                       done,
	output logic [pmse_pkg::VAL_W-1:0] quot,
	output logic [pmse_pkg::LEN_W-1:0] rem
);
	import pmse_pkg::*;

	logic              busy_q, done_q;
	logic [DIV_CW-1:0] cnt_q;
	logic [VAL_W-1:0]  quo_q;
	logic [LEN_W-1:0]  rem_q, dvs_q;
	logic [LEN_W:0]    trial, diff;
	logic              ge;

	// One quotient bit per cycle
	assign trial = {rem_q, quo_q[VAL_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CW'(VAL_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
			quo_q <= {quo_q[VAL_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quo_q;
	assign rem  = rem_q;

endmodule

[rtl/pmse_trellis.sv]
// Two-state shaping trellis: one shared multiplier runs the two-stage filter per symbol.
module pmse_trellis (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  pmse_pkg::trl_cfg_t           cfg,
	input  logic [pmse_pkg::RING_AW-1:0] rp,
	input  pmse_pkg::trl_st_t            init,
	input  logic [pmse_pkg::UC_W-1:0]    ring_ucode,
	input  logic [5:0]                   ring_shape,
	output logic [pmse_pkg::RING_AW-1:0] ring_addr,
	output logic                         done,
	output pmse_pkg::trl_st_t            result
);
	import pmse_pkg::*;

	trl_fsm_t              fsm_q, fsm_d;
	logic [1:0]            depth_q;
	logic                  st_q, ls_q, q_q;
	logic [2:0]            sym_q;
	logic [RING_AW-1:0]    ptr_q;
	logic [5:0]            sg_q;
	logic signed [X_W-1:0] x1_q, xn_q;
	logic signed [F_W-1:0] y1_q, v1_q, yn_q, vn_q;
	logic [EN_W-1:0]       w_q;
	logic signed [PROD_W-1:0] acc_q, prod_q, prod_d, sh_sum;
	logic signed [F_W-1:0] ma, mb;
	node_t                 cur_q [2];
	node_t                 nxt_q [2];
	node_t                 first_q [2];
	logic [1:0]            prev_q [4];
	logic [15:0]           mag;
	logic signed [X_W-1:0] xs;
	logic                  last_ls, take, sym_last, tb;

	// Signed sample of the current symbol
	assign mag = ucode_mag(ring_ucode);
	assign xs  = sg_q[sym_q] ? signed'({1'b0, mag}) : -signed'({1'b0, mag});

	// Shared multiplier operands
	always_comb begin
		ma = '0;
		mb = '0;
		case (fsm_q)
			T_MAG: begin ma = F_W'(cfg.a1); mb = y1_q; end
			T_P1:  begin ma = F_W'(cfg.b1); mb = F_W'(x1_q); end
			T_P2:  begin ma = F_W'(cfg.a2); mb = v1_q; end
			T_P3:  begin ma = F_W'(cfg.b2); mb = y1_q; end
			T_P5:  begin ma = vn_q; mb = vn_q; end
			default: begin ma = '0; mb = '0; end
		endcase
	end
	assign prod_d = PROD_W'(ma) * PROD_W'(mb);
	assign sh_sum = (acc_q - prod_q) >>> 6;

	assign sym_last = (sym_q == cfg.fs - 3'd1);
	assign last_ls  = (depth_q == 2'd0) || ls_q;
	assign take     = (depth_q == 2'd0) || !ls_q || (w_q < nxt_q[st_q].w);

	// Next state
	always_comb begin
		fsm_d = fsm_q;
		case (fsm_q)
			T_IDLE:  if (start) fsm_d = T_EDGE;
			T_EDGE:  fsm_d = T_MAG;
			T_MAG:   fsm_d = T_P1;
			T_P1:    fsm_d = T_P2;
			T_P2:    fsm_d = T_P3;
			T_P3:    fsm_d = T_P4;
			T_P4:    fsm_d = T_P5;
			T_P5:    fsm_d = T_P6;
			T_P6:    fsm_d = sym_last ? T_NEXT : T_MAG;
			T_NEXT:  fsm_d = (last_ls && st_q) ? T_DEPTH : T_EDGE;
			T_DEPTH: fsm_d = (depth_q == cfg.ld) ? T_DONE : T_EDGE;
			T_DONE:  fsm_d = T_IDLE;
			default: fsm_d = T_IDLE;
		endcase
	end

	// Outputs: ring address, completion, traceback from the best final node
	always_comb begin
		ring_addr = ptr_q + RING_AW'(sym_q);
		done      = (fsm_q == T_DONE);
		tb        = cur_q[1].w < cur_q[0].w;
		for (int d = 3; d >= 1; d--) begin
			if (2'(d) <= cfg.ld) begin
				tb = prev_q[d][tb];
			end
		end
		result.q = tb;
		result.t = first_q[tb].t;
		result.x = first_q[tb].x;
		result.y = first_q[tb].y;
		result.v = first_q[tb].v;
	end

	// Sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q   <= T_IDLE;
			depth_q <= '0;
			st_q    <= 1'b0;
			ls_q    <= 1'b0;
			q_q     <= 1'b0;
			sym_q   <= '0;
			ptr_q   <= '0;
		end else begin
			fsm_q <= fsm_d;
			case (fsm_q)
				T_IDLE: begin
					if (start) begin
						q_q     <= init.q;
						ls_q    <= init.q;
						st_q    <= 1'b0;
						depth_q <= '0;
						sym_q   <= '0;
						ptr_q   <= rp - RING_AW'(cfg.fs) * RING_AW'(cfg.ld);
					end
				end
				T_P6: sym_q <= sym_last ? 3'd0 : sym_q + 3'd1;
				T_NEXT: begin
					if (!last_ls) begin
						ls_q <= 1'b1;
					end else if (!st_q) begin
						st_q <= 1'b1;
						ls_q <= (depth_q == 2'd0) ? q_q : 1'b0;
					end
				end
				T_DEPTH: begin
					ptr_q   <= ptr_q + RING_AW'(cfg.fs);
					depth_q <= depth_q + 2'd1;
					st_q    <= 1'b0;
					ls_q    <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// Filter datapath and trellis nodes
	always_ff @(posedge clk) begin
		prod_q <= prod_d;
		case (fsm_q)
			T_IDLE: begin
				if (start) begin
					cur_q[init.q] <= '{t: init.t, x: init.x, y: init.y, v: init.v, w: '0};
				end
			end
			T_EDGE: begin
				sg_q <= cur_q[ls_q].t ^ ring_shape ^ sign_op({st_q, ls_q});
				x1_q <= cur_q[ls_q].x;
				y1_q <= cur_q[ls_q].y;
				v1_q <= cur_q[ls_q].v;
				w_q  <= cur_q[ls_q].w;
			end
			T_MAG: xn_q <= xs;
			T_P1:  acc_q <= prod_q;
			T_P2:  yn_q <= F_W'(sh_sum + PROD_W'(xn_q));
			T_P3:  acc_q <= prod_q;
			T_P4:  vn_q <= F_W'(sh_sum + PROD_W'(yn_q));
			T_P6: begin
				w_q  <= w_q + EN_W'(prod_q[PROD_W-1:4]);
				x1_q <= xn_q;
				y1_q <= yn_q;
				v1_q <= vn_q;
			end
			T_NEXT: begin
				if (take) begin
					nxt_q[st_q] <= '{t: sg_q, x: x1_q, y: y1_q, v: v1_q, w: w_q};
					prev_q[depth_q][st_q] <= ls_q;
				end
			end
			T_DEPTH: begin
				cur_q <= nxt_q;
				if (depth_q == 2'd0) begin
					first_q <= nxt_q;
				end
			end
			default: ;
		endcase
	end

endmodule

[rtl/pcm_mapper_shaping_encoder.sv]
// PCM mapper with spectral shaping: table loads, mixed-radix mapping, sign coding, output.
//
// Usage:
//  - Input channel (in_valid / in_stall / in_data): a load transaction writes one Ucode
//    table entry; an encode transaction carries one frame and yields one transaction of
//    six linear samples on the output channel.
//  - Configuration (cfg_we / cfg_index / cfg_data) is written by the user while
//    the block is idle; the block itself does not enforce it.
//  - An encode runs through six table lookups, each an iterative division (one quotient
//    bit per cycle, then a table RAM read). With shaping, each shaping frame filters
//    fs * (2 + 4 * lookahead) symbols on the single filter multiplier.
//  - An encode while any table is empty yields all-zero samples.
//  - in_stall is high while an encode is in progress; loads are taken every cycle while
//    no encode is in progress.
//  - The result sits in an output register; a stalled receiver holds it, and the next
//    input transaction is still accepted meanwhile.
//  - Reset sets configuration to defaults and clears table lengths, rings and trellis
//    state; table contents stay undefined until loaded.
module pcm_mapper_shaping_encoder (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  pmse_pkg::in_item_t    in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output pmse_pkg::out_item_t   out_data,
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_index,
	input  logic [7:0]            cfg_data
);
	import pmse_pkg::*;

	enc_state_t          state_q, state_d;
	logic [2:0]          shaping_bits_q;
	logic [5:0]          data_bits_q;
	logic [1:0]          lookahead_q;
	logic signed [7:0]   a1_q, b1_q, a2_q, b2_q;
	logic [LEN_W-1:0]    len_q [TABLE_POS];
	logic [UC_W-1:0]     ucode_ring_q [RING_DEPTH];
	logic [5:0]          shaping_ring_q [RING_DEPTH];
	logic [RING_AW-1:0]  rp_q, optr_q, rd_addr, trl_addr;
	logic                last_sign_q;
	trl_st_t             tst_q;
	logic [VAL_W-1:0]    v_q;
	logic [5:0]          d_q, signs_q;
	logic [2:0]          pos_q, oi_q;
	logic [1:0]          f_q;
	logic [5:0]          pv_q [3];
	logic signed [SAMP_W-1:0] samp_q [6];
	logic                out_valid_q;
	out_item_t           out_q;

	logic                accept, any_zero, load_ok, out_free;
	logic [2:0]          s_eff, fs_eff;
	logic [1:0]          ld_eff, nf_last;
	logic [FRAME_W-1:0]  fsh;
	logic [VAL_W-1:0]    vmask;
	logic [TBL_AW-1:0]   waddr, raddr;
	logic [UC_W-1:0]     ram_rdata, ring_ucode;
	logic [5:0]          ring_shape, diff_signs, fsmask;
	logic                diff_last, div_start, div_done, trl_start, trl_done;
	logic [VAL_W-1:0]    quot;
	logic [LEN_W-1:0]    rem;
	trl_cfg_t            tcfg;
	trl_st_t             tres;
	logic [15:0]         mag;
	logic signed [SAMP_W-1:0] samp;
	logic [2:0]          jsh;

	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign load_ok  = (in_data.table_pos < 3'(TABLE_POS)) &&
	                  (int'(in_data.table_index) < TABLE_DEPTH);

	// Effective frame layout
	always_comb begin
		any_zero = 1'b0;
		for (int i = 0; i < TABLE_POS; i++) begin
			if (len_q[i] == '0) any_zero = 1'b1;
		end
		s_eff = (shaping_bits_q < 3'd3) ? 3'd3 :
		        (shaping_bits_q == 3'd7) ? 3'd6 : shaping_bits_q;
		case (s_eff)
			3'd5:    begin fs_eff = 3'd6; nf_last = 2'd0; end
			3'd4:    begin fs_eff = 3'd3; nf_last = 2'd1; end
			3'd3:    begin fs_eff = 3'd2; nf_last = 2'd2; end
			default: begin fs_eff = 3'd6; nf_last = 2'd0; end
		endcase
		ld_eff = (s_eff == 3'd6) ? 2'd0 : lookahead_q;
		fsmask = 6'((7'd1 << fs_eff) - 7'd1);
		jsh    = 3'(f_q * fs_eff);
		fsh    = in_data.frame_bits >> s_eff;
		for (int j = 0; j < VAL_W; j++) begin
			vmask[j] = (j < int'(data_bits_q));
		end
		diff_last = last_sign_q;
		for (int i = 0; i < 6; i++) begin
			diff_last     = diff_last ^ d_q[i];
			diff_signs[i] = diff_last;
		end
	end

	// Table memory
	assign waddr = TBL_AW'(in_data.table_pos) * TBL_AW'(TABLE_DEPTH) +
	               TBL_AW'(in_data.table_index);
	assign raddr = TBL_AW'(pos_q) * TBL_AW'(TABLE_DEPTH) + TBL_AW'(rem[UC_W-1:0]);

	pmse_ram #(.WIDTH(UC_W), .DEPTH(TBL_WORDS)) u_tbl (
		.clk   (clk),
		.we    (accept && !in_data.req_type && load_ok),
		.waddr (waddr),
		.wdata (in_data.ucode_value),
		.raddr (raddr),
		.rdata (ram_rdata)
	);

	pmse_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (v_q),
		.divisor  (len_q[pos_q]),
		.done     (div_done),
		.quot     (quot),
		.rem      (rem)
	);

	assign tcfg = '{fs: fs_eff, ld: ld_eff, a1: a1_q, b1: b1_q, a2: a2_q, b2: b2_q};

	pmse_trellis u_trl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (trl_start),
		.cfg        (tcfg),
		.rp         (rp_q),
		.init       (tst_q),
		.ring_ucode (ring_ucode),
		.ring_shape (ring_shape),
		.ring_addr  (trl_addr),
		.done       (trl_done),
		.result     (tres)
	);

	// Ring read port and output sample
	assign rd_addr    = (state_q == ST_OUT) ? optr_q + RING_AW'(oi_q) : trl_addr;
	assign ring_ucode = ucode_ring_q[rd_addr];
	assign ring_shape = shaping_ring_q[rd_addr];
	assign mag        = ucode_mag(ring_ucode);
	assign samp       = signs_q[oi_q] ? signed'(mag) :
	                    (mag == 16'd0) ? -16'sd1 : -signed'(mag);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && in_data.req_type) begin
					state_d = any_zero ? ST_DONE : ST_DIV_GO;
				end
			end
			ST_DIV_GO:   state_d = ST_DIV_WAIT;
			ST_DIV_WAIT: if (div_done) state_d = ST_RING;
			ST_RING:     state_d = (pos_q == 3'd5) ? ST_SIGN : ST_DIV_GO;
			ST_SIGN:     state_d = (s_eff == 3'd6) ? ST_OPTR : ST_TRL_GO;
			ST_TRL_GO:   state_d = ST_TRL_WAIT;
			ST_TRL_WAIT: if (trl_done) state_d = (f_q == nf_last) ? ST_OPTR : ST_TRL_GO;
			ST_OPTR:     state_d = ST_OUT;
			ST_OUT:      if (oi_q == 3'd5) state_d = ST_DONE;
			ST_DONE:     if (out_free) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// Unit starts and handshake outputs
	always_comb begin
		div_start = (state_q == ST_DIV_GO);
		trl_start = (state_q == ST_TRL_GO);
		in_stall  = (state_q != ST_IDLE);
		out_valid = out_valid_q;
		out_data  = out_q;
	end

	// Configuration, tables lengths, rings and sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			shaping_bits_q <= 3'd6;
			data_bits_q    <= 6'd24;
			lookahead_q    <= '0;
			a1_q           <= '0;
			b1_q           <= '0;
			a2_q           <= '0;
			b2_q           <= '0;
			for (int i = 0; i < TABLE_POS; i++) len_q[i] <= '0;
			for (int i = 0; i < RING_DEPTH; i++) begin
				ucode_ring_q[i]   <= '0;
				shaping_ring_q[i] <= '0;
			end
			rp_q        <= '0;
			last_sign_q <= 1'b0;
			tst_q       <= '0;
			pos_q       <= '0;
			oi_q        <= '0;
			f_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					CFG_SHAPING_BITS: shaping_bits_q <= cfg_data[2:0];
					CFG_DATA_BITS:    data_bits_q    <= cfg_data[5:0];
					CFG_LOOKAHEAD:    lookahead_q    <= cfg_data[1:0];
					CFG_COEF_A1:      a1_q           <= signed'(cfg_data);
					CFG_COEF_B1:      b1_q           <= signed'(cfg_data);
					CFG_COEF_A2:      a2_q           <= signed'(cfg_data);
					CFG_COEF_B2:      b2_q           <= signed'(cfg_data);
					default: ;
				endcase
			end
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept && !in_data.req_type && load_ok && in_data.table_final) begin
						len_q[in_data.table_pos] <= LEN_W'(in_data.table_index) + 1'b1;
					end
					pos_q <= '0;
				end
				ST_RING: begin
					ucode_ring_q[rp_q + RING_AW'(pos_q)] <= ram_rdata;
					pos_q <= pos_q + 3'd1;
				end
				ST_SIGN: begin
					f_q <= '0;
					if (s_eff == 3'd6) begin
						last_sign_q <= diff_last;
						rp_q        <= rp_q + RING_AW'(6);
					end else if (s_eff == 3'd5) begin
						last_sign_q <= d_q[4] ^ d_q[2] ^ d_q[0] ^ last_sign_q;
					end else if (s_eff == 3'd4) begin
						last_sign_q <= d_q[2] ^ d_q[0] ^ last_sign_q;
					end else begin
						last_sign_q <= d_q[2] ^ d_q[1] ^ d_q[0] ^ last_sign_q;
					end
				end
				ST_TRL_GO: shaping_ring_q[rp_q] <= pv_q[f_q];
				ST_TRL_WAIT: begin
					if (trl_done) begin
						tst_q <= tres;
						rp_q  <= rp_q + RING_AW'(fs_eff);
						f_q   <= f_q + 2'd1;
					end
				end
				ST_OPTR: begin
					oi_q <= '0;
				end
				ST_OUT: oi_q <= oi_q + 3'd1;
				ST_DONE: begin
					if (out_free) out_valid_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// Frame payload, shaping inputs, signs and samples
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept && in_data.req_type) begin
					v_q <= fsh[VAL_W-1:0] & vmask;
					d_q <= in_data.frame_bits[5:0];
					for (int i = 0; i < 6; i++) samp_q[i] <= '0;
				end
			end
			ST_DIV_WAIT: if (div_done) v_q <= quot;
			ST_SIGN: begin
				signs_q <= (s_eff == 3'd6) ? diff_signs : 6'd0;
				pv_q[0] <= '0;
				pv_q[1] <= '0;
				pv_q[2] <= '0;
				if (s_eff == 3'd5) begin
					pv_q[0] <= {d_q[4] ^ d_q[2] ^ d_q[0] ^ last_sign_q, d_q[3],
					            d_q[2] ^ d_q[0] ^ last_sign_q, d_q[1],
					            d_q[0] ^ last_sign_q, 1'b0};
				end else if (s_eff == 3'd4) begin
					pv_q[0] <= {3'b000, d_q[1], d_q[0] ^ last_sign_q, 1'b0};
					pv_q[1] <= {3'b000, d_q[3], d_q[2] ^ d_q[0] ^ last_sign_q, 1'b0};
				end else if (s_eff == 3'd3) begin
					pv_q[0] <= {4'b0000, d_q[0] ^ last_sign_q, 1'b0};
					pv_q[1] <= {4'b0000, d_q[1] ^ d_q[0] ^ last_sign_q, 1'b0};
					pv_q[2] <= {4'b0000, d_q[2] ^ d_q[1] ^ d_q[0] ^ last_sign_q, 1'b0};
				end
			end
			ST_TRL_WAIT: begin
				if (trl_done) begin
					signs_q <= signs_q | 6'(12'(tres.t & fsmask) << jsh);
				end
			end
			ST_OPTR: optr_q <= rp_q - RING_AW'(6) - RING_AW'(fs_eff) * RING_AW'(ld_eff);
			ST_OUT: samp_q[oi_q] <= samp;
			ST_DONE: begin
				if (out_free) begin
					out_q.sample0 <= samp_q[0];
					out_q.sample1 <= samp_q[1];
					out_q.sample2 <= samp_q[2];
					out_q.sample3 <= samp_q[3];
					out_q.sample4 <= samp_q[4];
					out_q.sample5 <= samp_q[5];
				end
			end
			default: ;
		endcase
	end

endmodule
